// ----- rtl/ground_to_image_projection_assert.svh -----
// ============================================================================
// ground_to_image_projection assertion macros
// Shared clocking and check wrappers for the projection pipeline
// ============================================================================
`ifndef GROUND_TO_IMAGE_PROJECTION_ASSERT_SVH
`define GROUND_TO_IMAGE_PROJECTION_ASSERT_SVH

// clocking event with synchronous active-low reset
`define GTIP_CLOCKING @(posedge aclk) disable iff (!aresetn)

// named concurrent check reporting by error
`define GTIP_CHECK(lbl, prop, msg) \
    lbl: assert property (`GTIP_CLOCKING prop) else $error(msg);

`endif

// ----- rtl/gtip_pkg.sv -----
// ============================================================================
// gtip_pkg
// Types and constants shared by the ground-to-image projection pipeline
// ============================================================================
package gtip_pkg;

    localparam int COORD_FRAC_BITS = 8;
    localparam int PIXEL_BITS      = 24;
    localparam int COEF_N          = 9;
    localparam int DIV_CELLS       = 63;

    // quotient magnitude ceiling, 2^62
    localparam logic [62:0] QUOT_CLAMP = 63'd1 << 62;

    typedef enum logic {
        KIND_LOAD    = 1'b0,
        KIND_PROJECT = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        CFG_CAMERA_X     = 3'd0,
        CFG_CAMERA_Y     = 3'd1,
        CFG_CAMERA_Z     = 3'd2,
        CFG_FOCAL_LENGTH = 3'd3,
        CFG_PRINCIPAL_X  = 3'd4,
        CFG_PRINCIPAL_Y  = 3'd5,
        CFG_IMAGE_WIDTH  = 3'd6,
        CFG_IMAGE_HEIGHT = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic               kind;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [39:0] geo_x;
        logic signed [39:0] geo_y;
        logic signed [39:0] geo_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] pixel_x;
        logic signed [PIXEL_BITS-1:0] pixel_y;
        logic                         invalid;
    } out_beat_t;

    // sideband that travels with a beat through the divider cells
    typedef struct packed {
        logic       vld;
        logic       inv;
        logic [1:0] neg;
        logic [1:0] big;
    } div_side_t;

endpackage

// ----- rtl/gtip_term.sv -----
// ============================================================================
// gtip_term
// One collinearity term: three coefficient products, floored by 16 bits, summed
// ============================================================================
module gtip_term
    import gtip_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic signed [40:0] d_i    [3],
    input  logic signed [31:0] coef_i [3],
    output logic signed [58:0] t_o
);

    logic signed [53:0] plo_reg [3];
    logic signed [51:0] phi_reg [3];
    logic signed [56:0] fl_reg  [3];
    logic signed [72:0] prod    [3];
    logic signed [58:0] t_reg;

    // partial products over a split delta
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                plo_reg[k] <= coef_i[k] * $signed({1'b0, d_i[k][20:0]});
                phi_reg[k] <= coef_i[k] * $signed(d_i[k][40:21]);
            end
        end
    end

    // recombine and floor by 16 bits
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = (73'(phi_reg[k]) <<< 21) + 73'(plo_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                fl_reg[k] <= prod[k][72:16];
            end
            t_reg <= 59'(fl_reg[0]) + 59'(fl_reg[1]) + 59'(fl_reg[2]);
        end
    end

    assign t_o = t_reg;

endmodule

// ----- rtl/gtip_div_cell.sv -----
// ============================================================================
// gtip_div_cell
// One restoring division step for both quotient lanes
// ============================================================================
module gtip_div_cell
    import gtip_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  div_side_t             side_i,
    input  logic [57:0]           den_i,
    input  logic [1:0][57:0]      rem_i,
    input  logic [1:0][62:0]      num_i,
    input  logic [1:0][62:0]      quo_i,
    output div_side_t             side_o,
    output logic [57:0]           den_o,
    output logic [1:0][57:0]      rem_o,
    output logic [1:0][62:0]      num_o,
    output logic [1:0][62:0]      quo_o
);

    div_side_t        side_reg;
    logic [57:0]      den_reg;
    logic [1:0][57:0] rem_reg, rem_next;
    logic [1:0][62:0] num_reg, num_next;
    logic [1:0][62:0] quo_reg, quo_next;
    logic [1:0][58:0] trial;
    logic [1:0]       ge;

    // trial subtract of the divisor
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            trial[l]    = {rem_i[l], num_i[l][62]};
            ge[l]       = trial[l] >= {1'b0, den_i};
            rem_next[l] = ge[l] ? 58'(trial[l] - {1'b0, den_i}) : trial[l][57:0];
            quo_next[l] = {quo_i[l][61:0], ge[l]};
            num_next[l] = {num_i[l][61:0], 1'b0};
        end
    end

    // beat valid and payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.vld <= 1'b0;
        end else if (en) begin
            side_reg.vld <= side_i.vld;
        end
        if (en) begin
            side_reg.inv <= side_i.inv;
            side_reg.neg <= side_i.neg;
            side_reg.big <= side_i.big;
            den_reg      <= den_i;
            rem_reg      <= rem_next;
            num_reg      <= num_next;
            quo_reg      <= quo_next;
        end
    end

    assign side_o = side_reg;
    assign den_o  = den_reg;
    assign rem_o  = rem_reg;
    assign num_o  = num_reg;
    assign quo_o  = quo_reg;

endmodule

// ----- rtl/ground_to_image_projection.sv -----
// ============================================================================
// ground_to_image_projection
// Collinearity projection of ground points to pixels, fully pipelined
// ============================================================================
// beats pass stages 1 to 7, divider cells, stages 8 and 9 and the output register
// throughput: one beat per cycle; the 63 divider cells each resolve one quotient bit
// load beats write the coefficient table one stage in and give no result
// a stall on m_ready holds the whole pipeline in place
// reset (aresetn low, synchronous) clears all valids and loads register defaults
// the coefficient table has no reset and must be loaded before projecting
module ground_to_image_projection
    import gtip_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [39:0] cfg_wdata
);

    localparam logic signed [65:0] HALF = 66'((1 << COORD_FRAC_BITS) >> 1);
    localparam logic signed [65:0] RND  = 66'((1 << COORD_FRAC_BITS) - 1);
    localparam logic signed [65:0] PMAX = 66'((64'd1 << (PIXEL_BITS - 1)) - 1);
    localparam logic signed [65:0] PMIN = -PMAX - 66'sd1;

    // configuration registers
    logic signed [39:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [31:0]        focal_reg;
    logic signed [31:0] prin_x_reg, prin_y_reg;
    logic [15:0]        img_w_reg, img_h_reg;
    logic signed [31:0] coef_reg [COEF_N];

    logic adv;

    // stage 1
    logic               v1_reg, kind1_reg;
    logic [3:0]         idx1_reg;
    logic signed [31:0] val1_reg;
    logic signed [40:0] dx1_reg, dy1_reg, dz1_reg;
    logic signed [40:0] dvec [3];
    logic signed [31:0] cr1 [3], cr2 [3], cr3 [3];
    logic signed [58:0] t1, t2, t3;
    logic               v2_reg, v3_reg, v4_reg;

    // stages 5 to 7
    logic               v5_reg, inv5_reg;
    logic [1:0]         neg5_reg;
    logic [57:0]        m1_5_reg, m2_5_reg, d5_reg;
    logic               v6_reg, inv6_reg;
    logic [1:0]         neg6_reg;
    logic [57:0]        d6_reg;
    logic [1:0][60:0]   pl6_reg, ph6_reg;
    logic [1:0][89:0]   n7;
    logic [1:0]         big7;
    div_side_t          side7_reg;
    logic [57:0]        d7_reg;
    logic [1:0][57:0]   rem7_reg;
    logic [1:0][62:0]   num7_reg;

    // divider chain
    div_side_t          side_w [DIV_CELLS+1];
    logic [57:0]        den_w  [DIV_CELLS+1];
    logic [1:0][57:0]   rem_w  [DIV_CELLS+1];
    logic [1:0][62:0]   num_w  [DIV_CELLS+1];
    logic [1:0][62:0]   quo_w  [DIV_CELLS+1];

    // stages 8 to 10
    logic [1:0][62:0]   qc;
    logic               v8_reg, inv8_reg;
    logic signed [63:0] sq1_reg, sq2_reg;
    logic               v9_reg, inv9_reg;
    logic signed [65:0] vx9_reg, vy9_reg;
    logic signed [65:0] hwx, hhx;
    logic               m_valid_reg;
    out_beat_t          m_data_reg;

    function automatic logic signed [PIXEL_BITS-1:0] to_pixel(logic signed [65:0] v);
        logic signed [65:0] adj;
        logic signed [65:0] p;
        adj = (v < 0) ? v + RND : v;
        p   = adj >>> COORD_FRAC_BITS;
        if (p > PMAX) begin
            p = PMAX;
        end else if (p < PMIN) begin
            p = PMIN;
        end
        return p[PIXEL_BITS-1:0];
    endfunction

    // whole pipeline moves when the output register can take a beat
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg  <= '0;
            cam_y_reg  <= '0;
            cam_z_reg  <= '0;
            focal_reg  <= 32'd256;
            prin_x_reg <= '0;
            prin_y_reg <= '0;
            img_w_reg  <= 16'd1024;
            img_h_reg  <= 16'd1024;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CAMERA_X:     cam_x_reg  <= cfg_wdata;
                CFG_CAMERA_Y:     cam_y_reg  <= cfg_wdata;
                CFG_CAMERA_Z:     cam_z_reg  <= cfg_wdata;
                CFG_FOCAL_LENGTH: focal_reg  <= cfg_wdata[31:0];
                CFG_PRINCIPAL_X:  prin_x_reg <= cfg_wdata[31:0];
                CFG_PRINCIPAL_Y:  prin_y_reg <= cfg_wdata[31:0];
                CFG_IMAGE_WIDTH:  img_w_reg  <= cfg_wdata[15:0];
                CFG_IMAGE_HEIGHT: img_h_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // stage 1: accept beat, offset from camera
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            kind1_reg <= s_data.kind;
            idx1_reg  <= s_data.coef_index;
            val1_reg  <= s_data.coef_value;
            dx1_reg   <= 41'(s_data.geo_x) - 41'(cam_x_reg);
            dy1_reg   <= 41'(s_data.geo_y) - 41'(cam_y_reg);
            dz1_reg   <= 41'(s_data.geo_z) - 41'(cam_z_reg);
        end
    end

    // coefficient load, in order with projections read here
    always_ff @(posedge aclk) begin
        if (adv && v1_reg && kind1_reg == KIND_LOAD && idx1_reg < 4'(COEF_N)) begin
            coef_reg[idx1_reg] <= val1_reg;
        end
    end

    // stages 2 to 4: rotation terms
    assign dvec[0] = dx1_reg;
    assign dvec[1] = dy1_reg;
    assign dvec[2] = dz1_reg;
    assign cr1[0] = coef_reg[0];
    assign cr1[1] = coef_reg[3];
    assign cr1[2] = coef_reg[6];
    assign cr2[0] = coef_reg[1];
    assign cr2[1] = coef_reg[4];
    assign cr2[2] = coef_reg[7];
    assign cr3[0] = coef_reg[2];
    assign cr3[1] = coef_reg[5];
    assign cr3[2] = coef_reg[8];

    gtip_term u_term1 (.aclk(aclk), .en(adv), .d_i(dvec), .coef_i(cr1), .t_o(t1));
    gtip_term u_term2 (.aclk(aclk), .en(adv), .d_i(dvec), .coef_i(cr2), .t_o(t2));
    gtip_term u_term3 (.aclk(aclk), .en(adv), .d_i(dvec), .coef_i(cr3), .t_o(t3));

    // valids through the term stages, projections only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg && kind1_reg == KIND_PROJECT;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // stage 5: signs and magnitudes
    always_ff @(posedge aclk) begin
        if (adv) begin
            inv5_reg    <= t3 == '0;
            neg5_reg[0] <= t1[58] ^ t3[58];
            neg5_reg[1] <= t2[58] ^ t3[58];
            m1_5_reg    <= t1[58] ? 58'(-t1) : t1[57:0];
            m2_5_reg    <= t2[58] ? 58'(-t2) : t2[57:0];
            d5_reg      <= t3[58] ? 58'(-t3) : t3[57:0];
        end
    end

    // stage 6: focal length times magnitude, split in halves
    always_ff @(posedge aclk) begin
        if (adv) begin
            inv6_reg   <= inv5_reg;
            neg6_reg   <= neg5_reg;
            d6_reg     <= d5_reg;
            pl6_reg[0] <= 61'(focal_reg) * 61'(m1_5_reg[28:0]);
            ph6_reg[0] <= 61'(focal_reg) * 61'(m1_5_reg[57:29]);
            pl6_reg[1] <= 61'(focal_reg) * 61'(m2_5_reg[28:0]);
            ph6_reg[1] <= 61'(focal_reg) * 61'(m2_5_reg[57:29]);
        end
    end

    // stage 7: dividend, overflow check, first remainder
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n7[l]   = (90'(ph6_reg[l]) << 29) + 90'(pl6_reg[l]);
            big7[l] = {31'd0, n7[l][89:63]} >= d6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side7_reg.vld <= 1'b0;
        end else if (adv) begin
            side7_reg.vld <= v6_reg;
        end
        if (adv) begin
            side7_reg.inv <= inv6_reg;
            side7_reg.neg <= neg6_reg;
            side7_reg.big <= big7;
            d7_reg        <= d6_reg;
            for (int l = 0; l < 2; l++) begin
                rem7_reg[l] <= big7[l] ? '0 : 58'(n7[l][89:63]);
                num7_reg[l] <= n7[l][62:0];
            end
        end
    end

    // divider chain, one quotient bit per cell
    assign side_w[0] = side7_reg;
    assign den_w[0]  = d7_reg;
    assign rem_w[0]  = rem7_reg;
    assign num_w[0]  = num7_reg;
    assign quo_w[0]  = '0;

    for (genvar c = 0; c < DIV_CELLS; c++) begin : g_cell
        gtip_div_cell u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .en     (adv),
            .side_i (side_w[c]),
            .den_i  (den_w[c]),
            .rem_i  (rem_w[c]),
            .num_i  (num_w[c]),
            .quo_i  (quo_w[c]),
            .side_o (side_w[c+1]),
            .den_o  (den_w[c+1]),
            .rem_o  (rem_w[c+1]),
            .num_o  (num_w[c+1]),
            .quo_o  (quo_w[c+1])
        );
    end

    // stage 8: clamp and sign the quotients
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            qc[l] = (side_w[DIV_CELLS].big[l] || quo_w[DIV_CELLS][l] > QUOT_CLAMP)
                  ? QUOT_CLAMP : quo_w[DIV_CELLS][l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v8_reg      <= 1'b0;
            v9_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v8_reg      <= side_w[DIV_CELLS].vld;
            v9_reg      <= v8_reg;
            m_valid_reg <= v9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            inv8_reg <= side_w[DIV_CELLS].inv;
            sq1_reg  <= side_w[DIV_CELLS].neg[0] ? -$signed(64'(qc[0])) : $signed(64'(qc[0]));
            sq2_reg  <= side_w[DIV_CELLS].neg[1] ? -$signed(64'(qc[1])) : $signed(64'(qc[1]));
        end
    end

    // stage 9: principal point and image center
    assign hwx = $signed(66'(img_w_reg[15:1]) << COORD_FRAC_BITS);
    assign hhx = $signed(66'(img_h_reg[15:1]) << COORD_FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (adv) begin
            inv9_reg <= inv8_reg;
            vx9_reg  <= 66'(prin_x_reg) - 66'(sq1_reg) + hwx + HALF;
            vy9_reg  <= 66'(sq2_reg) - 66'(prin_y_reg) + hhx + HALF;
        end
    end

    // output register: truncate and saturate
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg.invalid <= inv9_reg;
            m_data_reg.pixel_x <= inv9_reg ? '0 : to_pixel(vx9_reg);
            m_data_reg.pixel_y <= inv9_reg ? '0 : to_pixel(vy9_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`include "ground_to_image_projection_assert.svh"

    `GTIP_CHECK(a_inv_zero, (m_valid_reg && m_data_reg.invalid |-> m_data_reg.pixel_x == '0 && m_data_reg.pixel_y == '0), "invalid beat with nonzero pixels")
    `GTIP_CHECK(a_load_no_result, (adv && v1_reg && kind1_reg == KIND_LOAD |=> !v2_reg), "load beat entered the term stages")
    `GTIP_CHECK(a_stall_holds, (!adv |=> $stable(v9_reg) && $stable(side7_reg.vld)), "pipeline moved during a stall")

endmodule
